@@ hw/rtl/fews_pkg.sv @@
// Package for the waiter selection block: table size, derived widths,
// the operation codes and the layout of one stored table entry.
// No dependencies.
package fews_pkg;

  localparam int MAX_WAITERS = 8;
  localparam int IDX_W       = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
  localparam int CNT_W       = $clog2(MAX_WAITERS + 1);

  typedef enum logic [1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_REMOVE = 2'd1,
    FUNC_QUERY  = 2'd2
  } func_t;

  typedef struct packed {
    logic [7:0]  id;
    logic [31:0] arrival;
    logic [31:0] deadline;
  } entry_t;

endpackage

@@ hw/rtl/fews_ram.sv @@
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module fews_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                         clk,
  input  logic                                         we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                             wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                             rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/fifo_edf_waiter_select.sv @@
// Top level of the waiter selection block: sequencer, result registers and
// the table memory. Depends on fews_pkg and fews_ram.
//
// The block keeps an ordered table of up to MAX_WAITERS waiting requesters in
// one RAM (id, arrival and deadline side by side in one word) and performs one
// operation per item: add, remove or query. An add needs no table walk:
// the entry is written straight into the RAM at the fill position, busy stays
// low and the next item may follow at once. A remove or a query walks the
// table through the RAM's read port, one entry a cycle, and keeps busy high
// until every stored entry has been read and dealt with. A remove closes
// the gap in the same pass, writing every entry after the match one place
// down as it is read. Each result appears on the result ports for exactly
// one cycle with done high, in the cycle after the operation completes;
// the receiver must take it then, as there is no way to hold it off. The
// table needs no clearing after reset: only data from positions below the
// fill count is ever used.
// The policy register may be written whenever busy is low.
module fifo_edf_waiter_select
  import fews_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // Item channel.
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func,
  input  logic [7:0]  requester_id,
  input  logic [31:0] arrival_time,
  input  logic [31:0] deadline_time,
  // Result channel.
  output logic        done,
  output logic        is_next,
  output logic        add_dropped,
  output logic        remove_found,
  output logic [3:0]  waiter_count,
  // Policy register write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] count;
  logic             policy_edf;

  // Scan bookkeeping: the read issue pointer and the tag of the entry whose
  // data the RAM returns in this cycle.
  logic [CNT_W-1:0] issue_ptr;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_tag;

  // The item under way.
  logic [1:0]       op;
  logic [7:0]       op_id;
  logic             found;

  // Best candidate so far during a query.
  logic [31:0]      best_arr;
  logic [31:0]      best_dl;
  logic [7:0]       best_id;

  // RAM ports.
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           ram_wdata;
  logic [IDX_W-1:0] ram_raddr;
  entry_t           ram_rdata;

  logic             accept;
  logic             full;
  logic             cand_beats;
  logic             scan_end;
  logic [CNT_W-1:0] count_dec;
  logic [CNT_W-1:0] count_inc;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = !busy;
  assign accept    = start && !busy;
  assign full      = (count == CNT_W'(MAX_WAITERS));
  assign count_inc = count + CNT_W'(1);
  assign count_dec = count - CNT_W'(1);

  // The scan is over once every stored entry has been read and the last
  // read's data has been dealt with.
  assign scan_end  = (issue_ptr == count) && !rd_vld;

  // Comparison of the entry coming out of the RAM with the best one so far.
  // A strict compare keeps the earlier position when the keys are equal.
  always_comb begin
    if (!policy_edf) begin
      cand_beats = ram_rdata.arrival < best_arr;
    end else if (ram_rdata.deadline != best_dl) begin
      cand_beats = ram_rdata.deadline < best_dl;
    end else begin
      cand_beats = ram_rdata.arrival < best_arr;
    end
  end

  // The add writes only while idle and the remove only while scanning, so
  // the two never meet on the write port. A remove writes each entry one
  // place below the one it was read from, which is always an address that
  // has already been read: the read and the write never hit the same entry.
  always_comb begin
    ram_raddr = issue_ptr[IDX_W-1:0];
    if (state == ST_IDLE) begin
      ram_we             = accept && (func == FUNC_ADD) && !full;
      ram_waddr          = count[IDX_W-1:0];
      ram_wdata.id       = requester_id;
      ram_wdata.arrival  = arrival_time;
      ram_wdata.deadline = deadline_time;
    end else begin
      ram_we    = rd_vld && (op == FUNC_REMOVE) && found;
      ram_waddr = rd_tag - IDX_W'(1);
      ram_wdata = ram_rdata;
    end
  end

  fews_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_WAITERS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequencer, table bookkeeping and result registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      policy_edf <= 1'b0;
      rd_vld     <= 1'b0;
      done       <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        policy_edf <= cfg_data;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op        <= func;
            op_id     <= requester_id;
            found     <= 1'b0;
            issue_ptr <= '0;
            rd_vld    <= 1'b0;
            case (func) inside
              FUNC_ADD: begin
                done         <= 1'b1;
                is_next      <= 1'b0;
                remove_found <= 1'b0;
                add_dropped  <= full;
                if (!full) begin
                  count        <= count_inc;
                  waiter_count <= 4'(count_inc);
                end else begin
                  waiter_count <= 4'(count);
                end
              end
              FUNC_REMOVE, FUNC_QUERY: begin
                state <= ST_SCAN;
              end
              default: begin
                // Unused code: nothing changes, the count is reported.
                done         <= 1'b1;
                is_next      <= 1'b0;
                remove_found <= 1'b0;
                add_dropped  <= 1'b0;
                waiter_count <= 4'(count);
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Issue side: one read a cycle over the filled positions.
          if (issue_ptr != count) begin
            issue_ptr <= issue_ptr + CNT_W'(1);
            rd_vld    <= 1'b1;
            rd_tag    <= issue_ptr[IDX_W-1:0];
          end else begin
            rd_vld    <= 1'b0;
          end
          // Data side: the entry read in the previous cycle.
          if (rd_vld) begin
            if (op == FUNC_REMOVE) begin
              if (!found && (ram_rdata.id == op_id)) begin
                found <= 1'b1;
              end
            end else if ((rd_tag == '0) || cand_beats) begin
              best_arr <= ram_rdata.arrival;
              best_dl  <= ram_rdata.deadline;
              best_id  <= ram_rdata.id;
            end
          end
          if (scan_end) begin
            state        <= ST_IDLE;
            done         <= 1'b1;
            add_dropped  <= 1'b0;
            if (op == FUNC_REMOVE) begin
              is_next      <= 1'b0;
              remove_found <= found;
              if (found) begin
                count        <= count_dec;
                waiter_count <= 4'(count_dec);
              end else begin
                waiter_count <= 4'(count);
              end
            end else begin
              is_next      <= (count != '0) && (best_id == op_id);
              remove_found <= 1'b0;
              waiter_count <= 4'(count);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The fill count never passes the table size.
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(MAX_WAITERS))
    else $error("waiter count beyond table size");

  // An accepted add gives its result in the very next cycle.
  a_add_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (func == FUNC_ADD)) |=> done)
    else $error("add without result");

  // A scan ends only together with its result.
  a_scan_result: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("scan ended without result");

  // During a scan the table is written only to close the gap behind a match.
  a_scan_write: assert property (@(posedge clk) disable iff (rst)
    (busy && ram_we) |-> ((op == FUNC_REMOVE) && found && (rd_tag != '0)))
    else $error("table written outside a remove shift");

endmodule

@@ tb/sv/fifo_edf_waiter_select_tb.sv @@
// Self-checking testbench for fifo_edf_waiter_select: directed and random items
// under both selection policies, checked against a table model kept here.
// Depends on fews_pkg and the block's RTL.
module fifo_edf_waiter_select_tb
  import fews_pkg::*;
();

  // The fourth operation code is left unassigned by the block and must change
  // nothing, so the testbench names it for its own use.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  // Far beyond the slowest correct run: about 570 items, each taking the block's
  // longest operation at worst, plus the sender's gaps in the sparsest phase.
  localparam int unsigned LIMIT_CYCLES = 200000;

  // One result item: the three flags and the fill count after the operation.
  typedef struct packed {
    logic       is_next;
    logic       add_dropped;
    logic       remove_found;
    logic [3:0] waiter_count;
  } outcome_t;

  // Mirror of the waiter table. It applies each accepted item to its own copy
  // of the table, works out the result that the block must give for it, and
  // keeps those results in order until the block's results arrive.
  class waiter_table_model;
    logic [7:0]  ids       [MAX_WAITERS];
    logic [31:0] arrivals  [MAX_WAITERS];
    logic [31:0] deadlines [MAX_WAITERS];
    int unsigned fill;
    logic        edf;
    outcome_t    pending_outcomes[$];
    int unsigned mismatches;

    function new();
      fill       = 0;
      edf        = 1'b0;
      mismatches = 0;
    endfunction

    // True when slot a is served before the best slot b found so far.
    function bit wins(int unsigned a, int unsigned b);
      if (!edf) return arrivals[a] < arrivals[b];
      if (deadlines[a] != deadlines[b]) return deadlines[a] < deadlines[b];
      return arrivals[a] < arrivals[b];
    endfunction

    // A later slot only wins on a strictly better key, so on equal keys the
    // earliest position stays selected.
    function int unsigned selected_slot();
      int unsigned best;
      best = 0;
      for (int unsigned i = 1; i < fill; i++) begin
        if (wins(i, best)) best = i;
      end
      return best;
    endfunction

    function void record_item(logic [1:0] op, logic [7:0] id, logic [31:0] arr,
                              logic [31:0] dl);
      outcome_t    o;
      int unsigned pos;
      o   = '0;
      pos = fill;
      case (op)
        FUNC_ADD: begin
          if (fill >= MAX_WAITERS) begin
            o.add_dropped = 1'b1;
          end else begin
            ids[fill]       = id;
            arrivals[fill]  = arr;
            deadlines[fill] = dl;
            fill++;
          end
        end
        FUNC_REMOVE: begin
          for (int unsigned i = 0; i < fill; i++) begin
            if (ids[i] == id) begin
              pos = i;
              break;
            end
          end
          if (pos < fill) begin
            for (int unsigned j = pos; j + 1 < fill; j++) begin
              ids[j]       = ids[j + 1];
              arrivals[j]  = arrivals[j + 1];
              deadlines[j] = deadlines[j + 1];
            end
            fill--;
            o.remove_found = 1'b1;
          end
        end
        FUNC_QUERY: begin
          if (fill != 0) o.is_next = (ids[selected_slot()] == id);
        end
        default: ;
      endcase
      o.waiter_count = fill[3:0];
      pending_outcomes.push_back(o);
    endfunction

    function void compare_outcome(logic nx, logic dropped, logic found, logic [3:0] cnt);
      outcome_t want;
      if (pending_outcomes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with no item outstanding: is_next=%b add_dropped=%b",
                   $time, nx, dropped, " remove_found=%b waiter_count=%0d", found, cnt);
        return;
      end
      want = pending_outcomes.pop_front();
      if (want.is_next !== nx || want.add_dropped !== dropped ||
          want.remove_found !== found || want.waiter_count !== cnt) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: expected is_next=%b add_dropped=%b remove_found=%b",
                   $time, want.is_next, want.add_dropped, want.remove_found,
                   " waiter_count=%0d, got is_next=%b add_dropped=%b", want.waiter_count,
                   nx, dropped, " remove_found=%b waiter_count=%0d", found, cnt);
      end
    endfunction
  endclass

  // Every input has a known value from time zero; reset is held from the start.
  logic        clk           = 1'b0;
  logic        rst           = 1'b1;
  logic        start         = 1'b0;
  logic [1:0]  func          = FUNC_ADD;
  logic [7:0]  requester_id  = 8'h00;
  logic [31:0] arrival_time  = 32'h0;
  logic [31:0] deadline_time = 32'h0;
  logic        cfg_valid     = 1'b0;
  logic        cfg_data      = 1'b0;
  logic        busy;
  logic        done;
  logic        is_next;
  logic        add_dropped;
  logic        remove_found;
  logic [3:0]  waiter_count;
  logic        cfg_ready;

  waiter_table_model model;
  int unsigned       idle_pct    = 0;
  int unsigned       fill_goal   = 0;
  int unsigned       cycle_count = 0;

  fifo_edf_waiter_select dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .requester_id  (requester_id),
    .arrival_time  (arrival_time),
    .deadline_time (deadline_time),
    .done          (done),
    .is_next       (is_next),
    .add_dropped   (add_dropped),
    .remove_found  (remove_found),
    .waiter_count  (waiter_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results cannot be held off, so every cycle with done high carries one
  // result that is checked straight away against the oldest expectation.
  // Outputs are read in the active region of the edge, before the block's own
  // updates land, so the value seen is the one of the cycle just ended.
  always @(posedge clk) begin
    if (!rst && done === 1'b1)
      model.compare_outcome(is_next, add_dropped, remove_found, waiter_count);
  end

  // A hung handshake or a lost result ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Offers one item and returns at the edge that takes it. Before the offer
  // the sender may stand idle for a while, as the current idle percentage
  // asks. When there is no gap, start simply stays high from the previous
  // item and only the fields change, so start gets one assignment per step.
  task automatic offer_item(logic [1:0] op, logic [7:0] id, logic [31:0] arr,
                            logic [31:0] dl);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    start         <= 1'b1;
    func          <= op;
    requester_id  <= id;
    arrival_time  <= arr;
    deadline_time <= dl;
    // The item is taken at the first edge at which busy was low.
    do @(posedge clk); while (busy !== 1'b0);
    model.record_item(op, id, arr, dl);
  endtask

  // Stops offering items and waits until every result has come back, which
  // leaves the block idle, since every item gives exactly one result.
  task automatic finish_phase();
    start <= 1'b0;
    while (model.pending_outcomes.size() != 0) @(posedge clk);
  endtask

  task automatic write_policy(logic value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    model.edf = value;
  endtask

  // Time stamps: small values give plenty of equal keys, the ends of the
  // range test the unsigned compare, and full-width values toggle every bit.
  function automatic logic [31:0] pick_stamp();
    case ($urandom_range(3))
      0:       return $urandom_range(15);
      1:       return $urandom_range(1) ? 32'hFFFF_FFFF - $urandom_range(3) : 32'h0;
      default: return $urandom();
    endcase
  endfunction

  // Random items steer the table towards a fill goal that moves now and
  // then, so that it runs full and empty in turn. Most removes and queries
  // name an id that is in the table, and half the queries name the requester
  // that would be served next, so that hits are common; the rest use small ids
  // that collide often or any id at all.
  task automatic offer_random_item();
    int unsigned r;
    logic [1:0]  op;
    logic [7:0]  id;
    r = $urandom_range(99);
    if (model.fill < fill_goal)
      op = (r < 60) ? FUNC_ADD : (r < 75) ? FUNC_REMOVE : (r < 96) ? FUNC_QUERY : FUNC_UNUSED;
    else
      op = (r < 15) ? FUNC_ADD : (r < 55) ? FUNC_REMOVE : (r < 96) ? FUNC_QUERY : FUNC_UNUSED;
    if (op == FUNC_QUERY && model.fill != 0 && $urandom_range(1))
      id = model.ids[model.selected_slot()];
    else if (model.fill != 0 && $urandom_range(99) < 60)
      id = model.ids[$urandom_range(model.fill - 1)];
    else if ($urandom_range(1))
      id = 8'($urandom_range(7));
    else
      id = 8'($urandom_range(255));
    offer_item(op, id, pick_stamp(), pick_stamp());
  endtask

  initial begin
    model = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed part under first-come-first-served, the policy after reset.
    // An empty table answers no to a query and finds nothing to remove, and
    // the unused code changes nothing.
    offer_item(FUNC_QUERY, 8'h00, 32'h0, 32'h0);
    offer_item(FUNC_REMOVE, 8'h00, 32'h0, 32'h0);
    offer_item(FUNC_UNUSED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Extreme ids and stamps, then an arrival tie, where the earlier table
    // position must win, and a duplicate id.
    offer_item(FUNC_ADD, 8'hFF, 32'hFFFF_FFFF, 32'h0);
    offer_item(FUNC_ADD, 8'h00, 32'h0, 32'hFFFF_FFFF);
    offer_item(FUNC_QUERY, 8'h00, 32'h0, 32'h0);
    offer_item(FUNC_QUERY, 8'hFF, 32'h0, 32'h0);
    offer_item(FUNC_ADD, 8'h11, 32'h0, 32'h0);
    offer_item(FUNC_QUERY, 8'h11, 32'h0, 32'h0);
    offer_item(FUNC_ADD, 8'h11, 32'h5, 32'h5);
    offer_item(FUNC_ADD, 8'hA5, 32'h5A5A_5A5A, 32'hA5A5_A5A5);
    offer_item(FUNC_ADD, 8'h5A, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    offer_item(FUNC_ADD, 8'h22, 32'h1, 32'h1);
    offer_item(FUNC_ADD, 8'h33, 32'h2, 32'h0);
    // The table is full now: this add is dropped.
    offer_item(FUNC_ADD, 8'h44, 32'h0, 32'h0);
    // Only the first of the two entries with id 11 goes; 99 is not there.
    offer_item(FUNC_REMOVE, 8'h11, 32'h0, 32'h0);
    offer_item(FUNC_REMOVE, 8'h99, 32'h0, 32'h0);
    offer_item(FUNC_QUERY, 8'h00, 32'h0, 32'h0);
    finish_phase();

    // Earliest deadline first: two entries share the smallest deadline and
    // the smaller arrival breaks the tie.
    write_policy(1'b1);
    offer_item(FUNC_QUERY, 8'h33, 32'h0, 32'h0);
    offer_item(FUNC_QUERY, 8'hFF, 32'h0, 32'h0);
    offer_item(FUNC_REMOVE, 8'h33, 32'h0, 32'h0);
    offer_item(FUNC_QUERY, 8'hFF, 32'h0, 32'h0);
    offer_item(FUNC_UNUSED, 8'h00, 32'h0, 32'h0);
    offer_item(FUNC_REMOVE, 8'hFF, 32'h0, 32'h0);
    offer_item(FUNC_QUERY, 8'h11, 32'h0, 32'h0);
    finish_phase();

    // Random part in six phases: the sender first idles in about a third of
    // the cycles, then in most of them, then never; each pace runs once under
    // each policy, and the policy is rewritten while the block is idle.
    for (int phase = 0; phase < 6; phase++) begin
      idle_pct = (phase < 2) ? 36 : (phase < 4) ? 84 : 0;
      write_policy(1'(phase % 2));
      for (int n = 0; n < 90; n++) begin
        if (n % 16 == 0) fill_goal = $urandom_range(MAX_WAITERS);
        offer_random_item();
      end
      finish_phase();
    end

    // Wait for longer than the longest operation takes, so that a stray result
    // would still be caught.
    repeat (20) @(posedge clk);
    if (model.mismatches == 0 && model.pending_outcomes.size() == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
